// ----- rtl/fat12cs_pkg.sv -----
// shared types and constants for the fat12 cluster chain sequencer
// no dependencies; imported by the top level
package fat12cs_pkg;

	localparam int TABLE_BYTES_DEF = 8192;

	localparam logic [11:0] ENTRY_MASK = 12'hFFF;
	localparam logic [11:0] END_MARK   = 12'hFF8;
	localparam logic [7:0]  BYTE_FILL  = 8'hFF;

	typedef enum logic [1:0] {
		OP_WRITE_TABLE = 2'd0,
		OP_OPEN_CHAIN  = 2'd1,
		OP_OPEN_ROOT   = 2'd2,
		OP_ADVANCE     = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_DATA_START = 1'b0,
		REG_SPC        = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INDEX,
		S_RD_LO,
		S_RD_HI,
		S_RD_WAIT,
		S_MUL,
		S_ADD1,
		S_ADD2,
		S_DONE
	} seq_state_t;

endpackage

// ----- rtl/fat12_cluster_chain_sequencer.sv -----
// fat12 cluster chain sequencer: table store, chain walker and sector address unit
// depends on fat12cs_pkg
//
// Walks FAT12 cluster chains one sector per advance request and returns, for
// every request, the sector address to read plus the current cluster, the
// sector offset in that cluster and a sticky end-of-chain flag. The allocation
// table lives in a single-port byte memory of TABLE_BYTES entries, loaded one
// byte per write request; it has no reset and bytes never written are not to
// be read. One request is worked at a time: a table write, a chain open, a
// root open or an advance that stays inside its cluster goes through the
// multiply, the two adds and the result load; an advance that crosses into
// the next cluster first computes the entry index and makes the two byte
// reads of the packed 12-bit entry through the one memory port. All sums
// (entry index, root increment, base plus cluster offset plus sector) share
// one 32-bit adder, and the cluster-times-spc product uses one small
// multiplier, registered before the adds. A new request may be taken while the
// previous result still waits on a stalled output. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module fat12_cluster_chain_sequencer #(
	parameter int TABLE_BYTES = fat12cs_pkg::TABLE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [12:0] table_address,
	input  logic [7:0]  table_byte,
	input  logic [11:0] start_cluster,
	input  logic [31:0] root_start_lba,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sector_lba,
	output logic        end_of_chain,
	output logic [11:0] cluster_now,
	output logic [6:0]  sector_index
);
	import fat12cs_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_BYTES);
	localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

	// table store, no reset
	logic [7:0] table_mem [TABLE_BYTES];

	seq_state_t state_q, state_d;

	// configuration registers
	logic [31:0] data_start_q;
	logic [7:0]  spc_q;

	// architectural walker state
	logic [11:0] cluster_q;
	logic [6:0]  offset_q;
	logic [31:0] root_sector_q;
	logic        root_mode_q;
	logic        ended_q;

	// working registers of the sequencer
	opcode_t     op_q;
	logic [12:0] idx_q;
	logic        odd_q;
	logic [7:0]  lo_q;
	logic [7:0]  rd_data_q;
	logic        rd_hit_q;
	logic [31:0] prod_q;
	logic [31:0] acc_q;

	// result register
	logic        out_valid_q;
	logic [31:0] lba_q;
	logic        eoc_q;
	logic [11:0] cl_out_q;
	logic [6:0]  sidx_q;

	// control
	logic        in_accept;
	opcode_t     in_op;
	logic [7:0]  off_next;
	logic        wrap;
	logic        out_free;
	logic        out_load;

	// shared adder
	logic [31:0] add_a, add_b, add_sum;

	// memory port
	logic [12:0] mem_addr;
	logic        mem_hit;
	logic        mem_we, mem_re;
	logic [7:0]  rd_byte;

	// next cluster and sector address pieces
	logic [15:0]        entry_word;
	logic [11:0]        next_cluster;
	logic [12:0]        cl_rel;
	logic signed [21:0] prod_full;

	assign in_op     = opcode_t'(opcode);
	assign in_accept = in_valid && !in_stall;
	assign off_next  = {1'b0, offset_q} + 8'd1;
	// wrap at spc, or at 128 where spc is larger; spc of zero wraps always
	assign wrap      = (off_next >= spc_q) || off_next[7];
	assign out_free  = !out_valid_q || !out_stall;

	assign add_sum = add_a + add_b;

	assign mem_hit = {1'b0, mem_addr} < TABLE_LIMIT;
	assign rd_byte = rd_hit_q ? rd_data_q : BYTE_FILL;

	// even cluster takes the low 12 bits, odd the high 12 bits
	assign entry_word   = {rd_byte, lo_q};
	assign next_cluster = odd_q ? entry_word[15:4] : (entry_word[11:0] & ENTRY_MASK);

	// (cluster - 2) as a signed value so the 32-bit product wraps like the
	// unsigned arithmetic
	assign cl_rel    = {1'b0, cluster_q} - 13'd2;
	assign prod_full = $signed(cl_rel) * $signed({1'b0, spc_q});

	// sequencer: next state, handshake and shared unit operands
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		add_a    = root_sector_q;
		add_b    = 32'd1;
		mem_addr = table_address;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					mem_we = (in_op == OP_WRITE_TABLE) && mem_hit;
					if (in_op == OP_ADVANCE && !root_mode_q && !ended_q && wrap)
						state_d = S_INDEX;
					else
						state_d = S_MUL;
				end
			end
			S_INDEX: begin
				// cluster * 3 / 2 = cluster + cluster / 2
				add_a   = {20'd0, cluster_q};
				add_b   = {21'd0, cluster_q[11:1]};
				state_d = S_RD_LO;
			end
			S_RD_LO: begin
				mem_addr = idx_q;
				mem_re   = mem_hit;
				add_a    = {19'd0, idx_q};
				add_b    = 32'd1;
				state_d  = S_RD_HI;
			end
			S_RD_HI: begin
				mem_addr = idx_q;
				mem_re   = mem_hit;
				state_d  = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_ADD1;
			end
			S_ADD1: begin
				add_a   = data_start_q;
				add_b   = prod_q;
				state_d = S_ADD2;
			end
			S_ADD2: begin
				add_a   = acc_q;
				add_b   = {25'd0, offset_q};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			spc_q        <= 8'd1;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_DATA_START: data_start_q <= cfg_data;
				REG_SPC:        spc_q        <= cfg_data[7:0];
				default:        spc_q        <= spc_q;
			endcase
		end
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_q     <= '0;
			offset_q      <= '0;
			root_sector_q <= '0;
			root_mode_q   <= 1'b0;
			ended_q       <= 1'b0;
		end else if (in_accept) begin
			case (in_op)
				OP_OPEN_CHAIN: begin
					cluster_q   <= start_cluster;
					offset_q    <= '0;
					root_mode_q <= 1'b0;
					ended_q     <= 1'b0;
				end
				OP_OPEN_ROOT: begin
					root_sector_q <= root_start_lba;
					root_mode_q   <= 1'b1;
					ended_q       <= 1'b0;
				end
				OP_ADVANCE: begin
					if (root_mode_q) begin
						root_sector_q <= add_sum;
					end else if (!ended_q) begin
						if (wrap) begin
							offset_q <= '0;
						end else begin
							offset_q <= off_next[6:0];
							// no cluster change, end check on the current one
							if (cluster_q >= END_MARK)
								ended_q <= 1'b1;
						end
					end
				end
				default: begin
					offset_q <= offset_q;
				end
			endcase
		end else if (state_q == S_RD_WAIT) begin
			cluster_q <= next_cluster;
			if (next_cluster >= END_MARK)
				ended_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_accept)
			op_q <= in_op;
		case (state_q)
			S_INDEX: begin
				idx_q <= add_sum[12:0];
				odd_q <= cluster_q[0];
			end
			S_RD_LO: begin
				idx_q    <= add_sum[12:0];
				rd_hit_q <= mem_hit;
			end
			S_RD_HI: begin
				lo_q     <= rd_byte;
				rd_hit_q <= mem_hit;
			end
			S_MUL: begin
				prod_q <= 32'(prod_full);
			end
			S_ADD1, S_ADD2: begin
				acc_q <= add_sum;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// single-port table memory
	always_ff @(posedge clk) begin
		if (mem_we)
			table_mem[mem_addr[ADDR_W-1:0]] <= table_byte;
		if (mem_re)
			rd_data_q <= table_mem[mem_addr[ADDR_W-1:0]];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (op_q == OP_WRITE_TABLE)
				lba_q <= '0;
			else if (root_mode_q)
				lba_q <= root_sector_q;
			else if (ended_q)
				lba_q <= '0;
			else
				lba_q <= acc_q;
			eoc_q    <= !root_mode_q && ended_q;
			cl_out_q <= root_mode_q ? 12'd0 : cluster_q;
			sidx_q   <= root_mode_q ? 7'd0 : offset_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sector_lba   = lba_q;
	assign end_of_chain = eoc_q;
	assign cluster_now  = cl_out_q;
	assign sector_index = sidx_q;

`ifndef SYNTHESIS
	// the end flag is never set in root mode
	a_end_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !root_mode_q)
		else $error("end of chain flagged in root mode");

	// the one memory port never reads and writes together
	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("table read and write in one cycle");

	// the two entry bytes are read on consecutive cycles
	a_fetch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_LO) |=> (state_q == S_RD_HI))
		else $error("entry fetch sequence broken");

	// a request is worked alone
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("second request taken while busy");

	// an ended chain reports no sector
	a_end_no_lba: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eoc_q) |-> (lba_q == 32'd0))
		else $error("sector address given after end of chain");
`endif

endmodule

// ----- tb/tb_fat12_cluster_chain_sequencer.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the fat12 cluster chain sequencer
// depends on fat12cs_pkg and fat12_cluster_chain_sequencer; predicts every sector result
module tb;
	import fat12cs_pkg::*;

	localparam int RANDOM_REQUESTS = 1750;
	localparam int WATCHDOG_CYCLES = 4000;
	// settle time after the last result, covering anything still in flight
	localparam int SETTLE_CYCLES   = 16;
	localparam int TBL_DEPTH       = TABLE_BYTES_DEF;

	typedef struct packed {
		logic [31:0] lba;
		logic        ended;
		logic [11:0] cluster;
		logic [6:0]  index;
	} sector_result_t;

	// dut ports
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_write      = 1'b0;
	logic        cfg_index      = REG_DATA_START;
	logic [31:0] cfg_data       = '0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode         = OP_ADVANCE;
	logic [12:0] table_address  = '0;
	logic [7:0]  table_byte     = '0;
	logic [11:0] start_cluster  = '0;
	logic [31:0] root_start_lba = '0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [31:0] sector_lba;
	logic        end_of_chain;
	logic [11:0] cluster_now;
	logic [6:0]  sector_index;

	// shadow of the block: allocation table, walker state and registers
	logic [7:0]  fat_copy [TBL_DEPTH];
	bit          byte_known [TBL_DEPTH];
	logic [11:0] walk_cluster = '0;
	logic [6:0]  walk_offset  = '0;
	logic [31:0] walk_root    = '0;
	bit          walk_in_root = 1'b0;
	bit          walk_ended   = 1'b0;
	logic [31:0] base_lba     = '0;
	logic [7:0]  spc_reg      = 8'd1;

	sector_result_t pending_sectors [$];
	int mismatches    = 0;
	int requests_sent = 0;
	int idle_cycles   = 0;
	// quiet turns off idling on both sides for a stretch of the run
	bit quiet         = 1'b0;

	fat12_cluster_chain_sequencer i_dut (.*);

	always #2 clk = ~clk;

	// receiver side: random stall, about a third of the cycles
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 32);
	end

	// watchdog: cycles in which nothing moves on any port
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		sector_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sectors.size() == 0) begin
				flag_mismatch("result with no request waiting");
			end else begin
				want = pending_sectors.pop_front();
				if (sector_lba !== want.lba)
					flag_mismatch($sformatf("sector_lba %h, want %h", sector_lba, want.lba));
				if (end_of_chain !== want.ended)
					flag_mismatch($sformatf("end_of_chain %b, want %b", end_of_chain,
						want.ended));
				if (cluster_now !== want.cluster)
					flag_mismatch($sformatf("cluster_now %h, want %h", cluster_now,
						want.cluster));
				if (sector_index !== want.index)
					flag_mismatch($sformatf("sector_index %0d, want %0d", sector_index,
						want.index));
			end
		end
	end

	// packed 12-bit entry: even clusters low 12 bits, odd ones high 12 bits
	function automatic logic [11:0] entry_of(input logic [11:0] c);
		int i;
		logic [15:0] word;
		i = (int'(c) * 3) / 2;
		word = {fat_copy[i + 1], fat_copy[i]};
		return c[0] ? word[15:4] : word[11:0];
	endfunction

	// true when the next advance crosses into the next cluster and reads the table
	function automatic bit advance_fetches();
		if (walk_in_root || walk_ended)
			return 1'b0;
		return (int'(walk_offset) + 1 >= int'(spc_reg)) || (walk_offset == 7'd127);
	endfunction

	function automatic int eff_spc();
		if (spc_reg == 8'd0)
			return 1;
		return (spc_reg > 8'd128) ? 128 : int'(spc_reg);
	endfunction

	// advance the shadow walker by one request and queue the sector it yields
	task automatic update_walk(input opcode_t op, input logic [12:0] addr,
			input logic [7:0] data, input logic [11:0] sc, input logic [31:0] root);
		sector_result_t r;
		case (op)
			OP_WRITE_TABLE: begin
				fat_copy[addr]   = data;
				byte_known[addr] = 1'b1;
			end
			OP_OPEN_CHAIN: begin
				walk_cluster = sc;
				walk_offset  = '0;
				walk_in_root = 1'b0;
				walk_ended   = 1'b0;
			end
			OP_OPEN_ROOT: begin
				walk_root    = root;
				walk_in_root = 1'b1;
				walk_ended   = 1'b0;
			end
			default: begin
				if (walk_in_root) begin
					walk_root = walk_root + 32'd1;
				end else if (!walk_ended) begin
					if (advance_fetches()) begin
						walk_offset  = '0;
						walk_cluster = entry_of(walk_cluster);
					end else begin
						walk_offset = walk_offset + 7'd1;
					end
					// end marks stick until the next open
					if (walk_cluster >= END_MARK)
						walk_ended = 1'b1;
				end
			end
		endcase
		if (walk_in_root) begin
			r = '{lba: walk_root, ended: 1'b0, cluster: '0, index: '0};
		end else begin
			r.lba     = walk_ended ? 32'd0 : base_lba
				+ (32'(walk_cluster) - 32'd2) * 32'(spc_reg) + 32'(walk_offset);
			r.ended   = walk_ended;
			r.cluster = walk_cluster;
			r.index   = walk_offset;
		end
		if (op == OP_WRITE_TABLE)
			r.lba = '0;
		pending_sectors.push_back(r);
	endtask

	// one request: random idle gap, present, hold until taken, then predict
	task automatic send_request(input opcode_t op, input logic [12:0] addr,
			input logic [7:0] data, input logic [11:0] sc, input logic [31:0] root);
		while (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		opcode         <= op;
		table_address  <= addr;
		table_byte     <= data;
		start_cluster  <= sc;
		root_start_lba <= root;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		update_walk(op, addr, data, sc, root);
		requests_sent++;
	endtask

	// unused fields carry random content
	task automatic write_table_byte(input logic [12:0] addr, input logic [7:0] data);
		send_request(OP_WRITE_TABLE, addr, data, 12'($urandom), $urandom);
	endtask

	task automatic open_chain(input logic [11:0] c);
		send_request(OP_OPEN_CHAIN, 13'($urandom), 8'($urandom), c, $urandom);
	endtask

	task automatic open_root(input logic [31:0] lba);
		send_request(OP_OPEN_ROOT, 13'($urandom), 8'($urandom), 12'($urandom), lba);
	endtask

	// never let the block fetch a table byte that was never loaded
	task automatic advance_sector();
		int i;
		if (advance_fetches()) begin
			i = (int'(walk_cluster) * 3) / 2;
			if (!byte_known[i])
				write_table_byte(13'(i), 8'($urandom));
			if (!byte_known[i + 1])
				write_table_byte(13'(i + 1), 8'($urandom));
		end
		send_request(OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
	endtask

	// rewrite one 12-bit entry, keeping the nibble that belongs to the neighbor
	task automatic set_entry(input logic [11:0] c, input logic [11:0] v);
		int i;
		logic [7:0] lo, hi;
		i  = (int'(c) * 3) / 2;
		lo = byte_known[i] ? fat_copy[i] : 8'($urandom);
		hi = byte_known[i + 1] ? fat_copy[i + 1] : 8'($urandom);
		if (!c[0]) begin
			lo      = v[7:0];
			hi[3:0] = v[11:8];
		end else begin
			lo[7:4] = v[3:0];
			hi      = v[11:4];
		end
		write_table_byte(13'(i), lo);
		write_table_byte(13'(i + 1), hi);
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_sectors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// registers only change while the block is idle
	task automatic set_register(input reg_index_t idx, input logic [31:0] v);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_DATA_START)
			base_lba = v;
		else
			spc_reg = v[7:0];
	endtask

	// build a linked chain ending in an end mark, then walk it
	task automatic walk_chain(input int len);
		logic [11:0] links [$];
		int steps;
		for (int k = 0; k < len; k++)
			links.push_back(12'($urandom_range(2, 4087)));
		for (int k = 0; k < len - 1; k++)
			set_entry(links[k], links[k + 1]);
		set_entry(links[len - 1], 12'($urandom_range(12'hFF8, 12'hFFF)));
		open_chain(links[0]);
		steps = len * eff_spc() + $urandom_range(0, 3);
		// broken walks stop part way
		if ($urandom_range(99) < 20)
			steps = $urandom_range(0, steps);
		repeat (steps) advance_sector();
	endtask

	task automatic random_request();
		case (opcode_t'($urandom_range(3)))
			OP_WRITE_TABLE: write_table_byte(13'($urandom), 8'($urandom));
			OP_OPEN_CHAIN:  open_chain(12'($urandom));
			OP_OPEN_ROOT: begin
				if ($urandom_range(3) == 0)
					open_root(32'hFFFF_FFFF - $urandom_range(0, 3));
				else
					open_root($urandom);
			end
			default:        advance_sector();
		endcase
	endtask

	// advance straight after reset, extreme table addresses and bytes
	task automatic test_reset_state();
		write_table_byte(13'd0, 8'h05);
		write_table_byte(13'd1, 8'h00);
		advance_sector();
		write_table_byte(13'h1FFF, 8'hFF);
		write_table_byte(13'h1FFE, 8'h00);
		advance_sector();
	endtask

	// end marks on odd and even clusters, sticky end, open without end check
	task automatic test_chain_end();
		set_entry(12'd3, 12'hFFF);
		open_chain(12'd3);
		advance_sector();
		advance_sector();
		open_chain(12'hFFF);
		set_entry(12'd4, 12'hFF8);
		open_chain(12'd4);
		advance_sector();
	endtask

	// root run with wrap of the sector counter, table write while in root mode
	task automatic test_root_walk();
		open_root(32'hFFFF_FFFF);
		advance_sector();
		advance_sector();
		write_table_byte(13'd100, 8'hA5);
		open_root(32'd0);
		open_chain(12'd0);
		advance_sector();
	endtask

	// largest base, zero and oversized sectors per cluster
	task automatic test_spc_extremes();
		set_register(REG_DATA_START, 32'hFFFF_FFFF);
		set_register(REG_SPC, 32'h0000_0000);
		open_chain(12'd0);
		advance_sector();
		advance_sector();
		set_register(REG_SPC, 32'hFFFF_FFFF);
		open_chain(12'hABC);
		repeat (3) advance_sector();
	endtask

	// phases of random settings, each mostly well-formed chain walks
	task automatic test_random_walks();
		int first, phase, pick, acts;
		logic [7:0] spc;
		first = requests_sent;
		phase = 0;
		while (requests_sent - first < RANDOM_REQUESTS) begin
			pick = $urandom_range(99);
			if (pick < 70)      spc = 8'($urandom_range(1, 4));
			else if (pick < 80) spc = 8'($urandom_range(5, 16));
			else if (pick < 87) spc = 8'd0;
			else if (pick < 92) spc = 8'd128;
			else if (pick < 96) spc = 8'($urandom_range(129, 255));
			else                spc = 8'($urandom_range(17, 127));
			pick = $urandom_range(9);
			set_register(REG_DATA_START, (pick == 0) ? 32'd0 :
				(pick == 1) ? 32'hFFFF_FFFF : $urandom);
			set_register(REG_SPC, {24'($urandom), spc});
			quiet = (phase == 3);
			acts = (eff_spc() > 16) ? 2 : $urandom_range(6, 12);
			repeat (acts) begin
				if (requests_sent - first >= RANDOM_REQUESTS)
					break;
				pick = $urandom_range(99);
				if (pick < 65)
					walk_chain((eff_spc() > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6));
				else if (pick < 80) begin
					open_root($urandom);
					repeat ($urandom_range(1, 8)) advance_sector();
				end else begin
					repeat ($urandom_range(1, 4)) random_request();
				end
			end
			phase++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_chain_end();
		test_root_walk();
		test_spc_extremes();
		test_random_walks();
		drain();
		if (mismatches == 0 && pending_sectors.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fat12cs_pkg.sv
rtl/fat12_cluster_chain_sequencer.sv
tb/tb_fat12_cluster_chain_sequencer.sv
